// File: hdl/upi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package upi_pkg;

   // cordic defaults and datapath widths
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int VEC_W            = 34;

   // gain-corrected start value, 0.6072529350 in q2.30
   localparam logic signed [VEC_W-1:0] CORDIC_GAIN = 34'sd652032874;

   // 2^30 / (2*pi), turns radians into binary angle
   localparam logic signed [31:0] RAD_TO_BAM = 32'sd170891319;

   // final scaling of all three products
   localparam int RND_SHIFT = 42;
   localparam logic signed [63:0] RND_HALF    = 64'sh0000_0200_0000_0000;
   localparam logic signed [63:0] RND_HALF_M1 = 64'sh0000_01FF_FFFF_FFFF;

   typedef struct packed {
      logic signed [VEC_W-1:0] x;
      logic signed [VEC_W-1:0] y;
      logic signed [VEC_W-1:0] z;
   } cordic_vec_type;

   // arctan(2^-i) in units of 2^-32 turn
   function automatic logic signed [VEC_W-1:0] atan_turns(input int idx);
      logic signed [VEC_W-1:0] val;
      case (idx)
         0:       val = 34'sd536870912;
         1:       val = 34'sd316933406;
         2:       val = 34'sd167458907;
         3:       val = 34'sd85004756;
         4:       val = 34'sd42667331;
         5:       val = 34'sd21354465;
         6:       val = 34'sd10679838;
         7:       val = 34'sd5340245;
         8:       val = 34'sd2670163;
         9:       val = 34'sd1335087;
         10:      val = 34'sd667544;
         11:      val = 34'sd333772;
         12:      val = 34'sd166886;
         13:      val = 34'sd83443;
         14:      val = 34'sd41722;
         15:      val = 34'sd20861;
         16:      val = 34'sd10430;
         17:      val = 34'sd5215;
         18:      val = 34'sd2608;
         19:      val = 34'sd1304;
         20:      val = 34'sd652;
         21:      val = 34'sd326;
         22:      val = 34'sd163;
         23:      val = 34'sd81;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

// File: hdl/upi_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module upi_cell #(
   parameter int SHIFT = 0
) (
   input  wire logic                    clock,
   input  wire upi_pkg::cordic_vec_type prev_vec,
   output upi_pkg::cordic_vec_type      vec_ff
);

   localparam logic signed [upi_pkg::VEC_W-1:0] ATAN = upi_pkg::atan_turns(SHIFT);

   logic signed [upi_pkg::VEC_W-1:0] x_sh;
   logic signed [upi_pkg::VEC_W-1:0] y_sh;
   upi_pkg::cordic_vec_type          vec_in;

   // shifts round toward minus infinity
   assign x_sh = prev_vec.x >>> SHIFT;
   assign y_sh = prev_vec.y >>> SHIFT;

   always_comb begin
      if (!prev_vec.z[upi_pkg::VEC_W-1]) begin
         vec_in.x = prev_vec.x - y_sh;
         vec_in.y = prev_vec.y + x_sh;
         vec_in.z = prev_vec.z - ATAN;
      end else begin
         vec_in.x = prev_vec.x + y_sh;
         vec_in.y = prev_vec.y - x_sh;
         vec_in.z = prev_vec.z + ATAN;
      end
   end

   always_ff @(posedge clock) begin
      vec_ff <= vec_in;
   end

endmodule

`default_nettype wire

// File: hdl/upi_cordic.sv
`timescale 1ns / 1ps
`default_nettype none

module upi_cordic #(
   parameter int STEPS = upi_pkg::CORDIC_STEPS_DEF
) (
   input  wire logic                    clock,
   input  wire upi_pkg::cordic_vec_type start_vec,
   output upi_pkg::cordic_vec_type      end_vec
);

   upi_pkg::cordic_vec_type stage_vec [0:STEPS];

   assign stage_vec[0] = start_vec;

   // one micro-rotation per cell, shift grows by one along the row
   for (genvar i = 0; i < STEPS; i++) begin : g_cell
      upi_cell #(
         .SHIFT (i)
      ) u_cell (
         .clock    (clock),
         .prev_vec (stage_vec[i]),
         .vec_ff   (stage_vec[i+1])
      );
   end

   assign end_vec = stage_vec[STEPS];

endmodule

`default_nettype wire

// File: hdl/unicycle_pose_integrator.sv
`timescale 1ns / 1ps
`default_nettype none

// unicycle pose integrator: euler dead reckoning of a planar pose
// req channel carries one tick item: speed (q4.12), turn rate (q4.12) and
// the tick interval (q0.16 s); rsp channel returns the updated pose
// (x, y in q16.16 m, saturating; heading as a 16-bit wrapping binary angle)
// sine and cosine of the old heading come from a row of cordic cells, one
// micro-rotation each, followed by a sign-fix stage, a multiply stage, a
// rounding stage and the accumulate stage
// a finished item is loaded into the rsp register once that register is
// free; req_stall stays high from accept until that load, so only one
// item is in the cell row at a time, since the next heading depends on
// this item's update
// a new item is taken while an earlier result still sits in the rsp
// register; a finished item waits for that register before going out
// reset clears pose, heading and all control; rsp_valid drops and req_stall
// stays high while reset is held
// when the receiver stalls, the rsp fields hold until taken
module unicycle_pose_integrator #(
   parameter int CORDIC_STEPS = upi_pkg::CORDIC_STEPS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // tick input
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic signed [15:0] req_linear_speed,
   input  wire logic signed [15:0] req_turn_rate,
   input  wire logic        [15:0] req_tick_interval,
   // pose output
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [31:0]      rsp_pos_x,
   output logic signed [31:0]      rsp_pos_y,
   output logic        [15:0]      rsp_heading
);

   // cycle count at which the rounded steps are ready to accumulate
   localparam int DONE_CNT = CORDIC_STEPS + 3;
   localparam int CNT_W    = $clog2(DONE_CNT + 1);
   localparam int VW       = upi_pkg::VEC_W;
   localparam int RS       = upi_pkg::RND_SHIFT;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_WAIT = 3'b100
   } state_type;

   state_type  state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   logic req_take;
   logic done;
   logic rsp_load;

   // pose state
   logic signed [31:0] x_ff, x_in;
   logic signed [31:0] y_ff, y_in;
   logic        [15:0] yaw_ff, yaw_in;

   // prep stage, loaded at accept
   logic signed [31:0]      dist_ff;
   logic signed [31:0]      p_ff;
   logic                    flip_ff;
   upi_pkg::cordic_vec_type start_vec_ff;
   logic signed [32:0]      dist_full;
   logic signed [32:0]      p_full;
   logic [15:0]             qtr_turn;
   logic                    flip_in;
   logic [15:0]             angle;
   upi_pkg::cordic_vec_type start_vec_in;

   // cordic row output and later stages
   upi_pkg::cordic_vec_type end_vec;
   logic signed [VW-1:0]    cos_wide;
   logic signed [VW-1:0]    sin_wide;
   logic signed [31:0]      cos_ff, sin_ff;
   logic signed [63:0]      prod_x_ff, prod_y_ff, prod_w_ff;
   logic signed [63:0]      prod_x_in, prod_y_in, prod_w_in;
   logic signed [63:0]      rsum_x, rsum_y, rsum_w;
   logic signed [63-RS:0]   dx_ff, dy_ff;
   logic        [15:0]      dyaw_ff;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_x_ff, rsp_y_ff;
   logic        [15:0] rsp_yaw_ff;

   // saturating add of a rounded step onto a q16.16 position
   function automatic logic signed [31:0] sat_add(input logic signed [31:0] acc,
                                                 input logic signed [63-RS:0] step);
      logic signed [33:0] sum;
      logic signed [31:0] res;
      sum = 34'(acc) + 34'(step);
      if (sum[33:31] == 3'b000 || sum[33:31] == 3'b111) begin
         res = sum[31:0];
      end else if (sum[33]) begin
         res = 32'sh8000_0000;
      end else begin
         res = 32'sh7FFF_FFFF;
      end
      return res;
   endfunction

   // handshake
   assign req_take  = req_valid && !req_stall;
   assign req_stall = reset || (state_ff != ST_IDLE);
   assign done      = (state_ff == ST_RUN) && (cnt_ff == CNT_W'(DONE_CNT));
   assign rsp_load  = (state_ff == ST_WAIT) && (!rsp_valid_ff || !rsp_stall);

   // control
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_RUN;
               cnt_in   = '0;
            end
         end
         ST_RUN: begin
            cnt_in = cnt_ff + 1'b1;
            if (done) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // prep: distance and angle products, cordic seed from the old heading
   assign dist_full = req_linear_speed * $signed({1'b0, req_tick_interval});
   assign p_full    = req_turn_rate * $signed({1'b0, req_tick_interval});

   // left half-plane headings are turned by half a turn, results negated later
   assign qtr_turn = yaw_ff + 16'd16384;
   assign flip_in  = qtr_turn[15];
   assign angle    = flip_in ? (yaw_ff ^ 16'h8000) : yaw_ff;

   always_comb begin
      start_vec_in.x = upi_pkg::CORDIC_GAIN;
      start_vec_in.y = '0;
      start_vec_in.z = {{(VW-32){angle[15]}}, angle, 16'h0000};
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         dist_ff      <= dist_full[31:0];
         p_ff         <= p_full[31:0];
         flip_ff      <= flip_in;
         start_vec_ff <= start_vec_in;
      end
   end

   upi_cordic #(
      .STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock     (clock),
      .start_vec (start_vec_ff),
      .end_vec   (end_vec)
   );

   // sign fix, results fit q2.30 in 32 bits
   assign cos_wide = flip_ff ? -end_vec.x : end_vec.x;
   assign sin_wide = flip_ff ? -end_vec.y : end_vec.y;

   // multiply
   assign prod_x_in = dist_ff * cos_ff;
   assign prod_y_in = dist_ff * sin_ff;
   assign prod_w_in = p_ff * upi_pkg::RAD_TO_BAM;

   // round to nearest, ties away from zero, in one add before the shift
   assign rsum_x = prod_x_ff + (prod_x_ff[63] ? upi_pkg::RND_HALF_M1 : upi_pkg::RND_HALF);
   assign rsum_y = prod_y_ff + (prod_y_ff[63] ? upi_pkg::RND_HALF_M1 : upi_pkg::RND_HALF);
   assign rsum_w = prod_w_ff + (prod_w_ff[63] ? upi_pkg::RND_HALF_M1 : upi_pkg::RND_HALF);

   // datapath stages run every cycle, sampled once by the done strobe
   always_ff @(posedge clock) begin
      cos_ff    <= cos_wide[31:0];
      sin_ff    <= sin_wide[31:0];
      prod_x_ff <= prod_x_in;
      prod_y_ff <= prod_y_in;
      prod_w_ff <= prod_w_in;
      dx_ff     <= rsum_x[63:RS];
      dy_ff     <= rsum_y[63:RS];
      dyaw_ff   <= rsum_w[RS+15:RS];
   end

   // pose accumulate, heading wraps
   always_comb begin
      x_in   = x_ff;
      y_in   = y_ff;
      yaw_in = yaw_ff;
      if (done) begin
         x_in   = sat_add(x_ff, dx_ff);
         y_in   = sat_add(y_ff, dy_ff);
         yaw_in = yaw_ff + dyaw_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff   <= '0;
         y_ff   <= '0;
         yaw_ff <= '0;
      end else begin
         x_ff   <= x_in;
         y_ff   <= y_in;
         yaw_ff <= yaw_in;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_x_ff   <= x_ff;
         rsp_y_ff   <= y_ff;
         rsp_yaw_ff <= yaw_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_pos_x   = rsp_x_ff;
   assign rsp_pos_y   = rsp_y_ff;
   assign rsp_heading = rsp_yaw_ff;

   // an accepted item starts the run from the first count
   a_start: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == ST_RUN && cnt_ff == '0))
      else $error("run did not start after accept");

   // the counter never passes the accumulate point
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (cnt_ff <= CNT_W'(DONE_CNT)))
      else $error("run counter out of range");

   // heading only moves on the accumulate strobe
   a_yaw_hold: assert property (@(posedge clock) disable iff (reset)
      !done |=> $stable(yaw_ff))
      else $error("heading changed outside accumulate");

   // a fresh result only comes from a finished item
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_WAIT))
      else $error("result raised without a finished item");

   // a finished item is never dropped by leaving wait without loading
   a_wait_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WAIT && !rsp_load) |=> (state_ff == ST_WAIT))
      else $error("left wait without loading the result");

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

   // cordic depth of the block under test, kept in step with the instance
   localparam int STEPS = upi_pkg::CORDIC_STEPS_DEF;

   // stimulus sizes
   localparam int RANDOM_TICKS = 1000;
   localparam int QUIET_TICKS  = 200;
   localparam int PRESSURE_AT  = 400;
   localparam int LONG_HOLD    = 600;
   localparam int DRAIN_CYCLES = 2 * (STEPS + 6);
   localparam int CYCLE_LIMIT  = 3000000;

   // odometry constants: cordic start value in q2.30, radians to binary angle in q30
   localparam longint GAIN_Q30   = 64'sd652032874;
   localparam longint RAD_TO_BAM = 64'sd170891319;
   localparam int     OUT_SHIFT  = 42;

   // arctan(2^-i) in units of 2^-32 turn
   localparam longint ATAN_TURNS [24] = '{
      64'sd536870912, 64'sd316933406, 64'sd167458907, 64'sd85004756,
      64'sd42667331,  64'sd21354465,  64'sd10679838,  64'sd5340245,
      64'sd2670163,   64'sd1335087,   64'sd667544,    64'sd333772,
      64'sd166886,    64'sd83443,     64'sd41722,     64'sd20861,
      64'sd10430,     64'sd5215,      64'sd2608,      64'sd1304,
      64'sd652,       64'sd326,       64'sd163,       64'sd81
   };

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic        [15:0] heading;
   } pose_type;

   // one row of the directed table; typed rows carry their pose by hand
   typedef struct packed {
      logic signed [15:0] speed;
      logic signed [15:0] turn;
      logic        [15:0] interval;
      logic        [15:0] reps;
      logic               typed;
      pose_type           pose;
   } tick_row_type;

   localparam int N_ROWS = 17;

   tick_row_type tick_table [N_ROWS] = '{
      // after reset, zero interval: pose stays at the origin
      '{16'sd0,      16'sd0,      16'd0,     16'd1,    1'b1, '{32'sd0, 32'sd0, 16'd0}},
      // no speed, no turn, full interval
      '{16'sd0,      16'sd0,      16'd65535, 16'd1,    1'b1, '{32'sd0, 32'sd0, 16'd0}},
      // zero interval with the field extremes
      '{16'sd32767,  16'sd32767,  16'd0,     16'd1,    1'b1, '{32'sd0, 32'sd0, 16'd0}},
      '{16'sh8000,   16'sh8000,   16'd0,     16'd1,    1'b1, '{32'sd0, 32'sd0, 16'd0}},
      // long straight run at full speed along heading zero
      '{16'sd32767,  16'sd0,      16'd65535, 16'd250,  1'b0, '0},
      // quarter turn clockwise
      '{16'sd0,      -16'sd6434,  16'd65535, 16'd1,    1'b0, '0},
      // long straight run at full speed toward minus y
      '{16'sd32767,  16'sd0,      16'd65535, 16'd250,  1'b0, '0},
      // zero interval away from the origin
      '{16'sd1000,   16'sd1000,   16'd0,     16'd1,    1'b0, '0},
      // full reverse, then full forward
      '{16'sh8000,   16'sd0,      16'd65535, 16'd3,    1'b0, '0},
      '{16'sd32767,  16'sd0,      16'd65535, 16'd3,    1'b0, '0},
      // heading wraps past a full turn both ways
      '{16'sd0,      16'sd32767,  16'd65535, 16'd2,    1'b0, '0},
      '{16'sd0,      16'sh8000,   16'd65535, 16'd2,    1'b0, '0},
      // one metre per second, one radian per second, tenth of a second
      '{16'sd4096,   16'sd4096,   16'd6554,  16'd4,    1'b0, '0},
      // smallest steps
      '{16'sd1,      16'sd1,      16'd1,     16'd1,    1'b0, '0},
      '{-16'sd1,     -16'sd1,     16'd65535, 16'd1,    1'b0, '0},
      // half turn, then drive through the left half plane
      '{16'sd0,      16'sd12868,  16'd65535, 16'd1,    1'b0, '0},
      '{16'sd12345,  -16'sd20000, 16'd40000, 16'd2,    1'b0, '0}
   };

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [15:0] req_linear_speed = '0;
   logic signed [15:0] req_turn_rate = '0;
   logic        [15:0] req_tick_interval = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_pos_x;
   logic signed [31:0] rsp_pos_y;
   logic        [15:0] rsp_heading;

   // sideband that travels with each offered item, driven like the payload
   logic     tick_typed = 1'b0;
   pose_type tick_typed_pose = '0;

   pose_type pose_now = '0;          // predicted pose after the last accepted item
   pose_type pending_poses [$];      // poses owed by the block, oldest first
   int       error_count = 0;
   int       cycle_count = 0;

   // idling control shared by the two sides
   int    idle_odds = 3;
   logic  quiet_tail = 1'b0;
   logic  hold_request = 1'b0;
   logic  hold_busy = 1'b0;
   logic  hold_done = 1'b0;

   unicycle_pose_integrator #(
      .CORDIC_STEPS(STEPS)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_linear_speed (req_linear_speed),
      .req_turn_rate    (req_turn_rate),
      .req_tick_interval(req_tick_interval),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pos_x        (rsp_pos_x),
      .rsp_pos_y        (rsp_pos_y),
      .rsp_heading      (rsp_heading)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // rounding shift by the output scale, ties away from zero
   function automatic longint round_out(input longint v);
      longint half;
      half = 64'sd1 <<< (OUT_SHIFT - 1);
      if (v >= 0) return (v + half) >>> OUT_SHIFT;
      return -((-v + half) >>> OUT_SHIFT);
   endfunction

   // cosine and sine of a binary angle in q2.30
   function automatic void heading_cos_sin(input logic [15:0] angle,
                                           output longint c, output longint s);
      logic [15:0] quarter;
      logic        flip;
      logic [15:0] folded;
      longint      x, y, z, nx;
      int          n;
      // left half plane: rotate by half a turn, negate both at the end
      quarter = angle + 16'd16384;
      flip    = quarter[15];
      folded  = flip ? angle ^ 16'h8000 : angle;
      x = GAIN_Q30;
      y = 0;
      z = longint'($signed(folded)) * 65536;
      n = (STEPS > 24) ? 24 : STEPS;
      for (int i = 0; i < n; i++) begin
         // arithmetic shifts of longint round toward minus infinity
         if (z >= 0) begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            z  = z - ATAN_TURNS[i];
         end else begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            z  = z + ATAN_TURNS[i];
         end
         x = nx;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   function automatic logic signed [31:0] clamp32(input longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   // one euler step of the pose, position first from the old heading
   function automatic pose_type advance_pose(input pose_type cur,
                                             input logic signed [15:0] speed,
                                             input logic signed [15:0] turn,
                                             input logic [15:0] interval);
      longint   c, s, travel, arc, step_bam;
      pose_type nxt;
      heading_cos_sin(cur.heading, c, s);
      travel = longint'(speed) * longint'(interval);
      nxt.x = clamp32(longint'(cur.x) + round_out(travel * c));
      nxt.y = clamp32(longint'(cur.y) + round_out(travel * s));
      arc = longint'(turn) * longint'(interval);
      step_bam = round_out(arc * RAD_TO_BAM);
      nxt.heading = cur.heading + step_bam[15:0];
      return nxt;
   endfunction

   // one of the corner values of a 16-bit field
   function automatic logic [15:0] corner16();
      case ($urandom_range(0, 4))
         0:       return 16'h0000;
         1:       return 16'h0001;
         2:       return 16'h7FFF;
         3:       return 16'h8000;
         default: return 16'hFFFF;
      endcase
   endfunction

   // offer one tick item and hold it until the block takes it
   task automatic offer_tick(input logic signed [15:0] speed,
                             input logic signed [15:0] turn,
                             input logic [15:0] interval,
                             input logic typed, input pose_type typed_pose);
      if (!quiet_tail && !hold_busy && idle_odds != 0
          && $urandom_range(0, idle_odds) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_linear_speed  <= speed;
      req_turn_rate     <= turn;
      req_tick_interval <= interval;
      tick_typed        <= typed;
      tick_typed_pose   <= typed_pose;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // scoreboard: check the result channel, then log the accepted tick
   always @(posedge clock) begin
      pose_type want;
      pose_type owed;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_poses.size() == 0) begin
               $error("pose item with none expected: x %0d y %0d heading %0d",
                      rsp_pos_x, rsp_pos_y, rsp_heading);
               error_count++;
            end else begin
               want = pending_poses.pop_front();
               if (rsp_pos_x !== want.x) begin
                  $error("pos_x expected %0d actual %0d", want.x, rsp_pos_x);
                  error_count++;
               end
               if (rsp_pos_y !== want.y) begin
                  $error("pos_y expected %0d actual %0d", want.y, rsp_pos_y);
                  error_count++;
               end
               if (rsp_heading !== want.heading) begin
                  $error("heading expected %0d actual %0d", want.heading, rsp_heading);
                  error_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            // predictor always advances; typed rows replace what is owed
            pose_now = advance_pose(pose_now, req_linear_speed, req_turn_rate,
                                    req_tick_interval);
            owed = tick_typed ? tick_typed_pose : pose_now;
            pending_poses = {pending_poses, owed};
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL unicycle_pose_integrator");
         $finish;
      end
   end

   // receiver: random stall bursts, one long hold-off, then a clean tail
   initial begin
      while (reset) @(posedge clock);
      forever begin
         if (hold_request && !hold_done) begin
            // long hold-off so the block fills and stalls its input
            hold_busy = 1'b1;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            hold_done = 1'b1;
            hold_busy = 1'b0;
         end else if (quiet_tail) begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            if ($urandom_range(0, 7) == 0)
               repeat ($urandom_range(100, 300)) @(posedge clock);
            else
               repeat ($urandom_range(1, 30)) @(posedge clock);
         end
      end
   end

   // sender: directed table, then random ticks, then drain and verdict
   initial begin
      logic signed [15:0] speed;
      logic signed [15:0] turn;
      logic        [15:0] interval;
      int                 kind;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows, each repeated as the row asks
      foreach (tick_table[r]) begin
         for (int k = 0; k < tick_table[r].reps; k++) begin
            offer_tick(tick_table[r].speed, tick_table[r].turn, tick_table[r].interval,
                       tick_table[r].typed, tick_table[r].pose);
         end
      end

      // random ticks, mostly plausible motion with noise and corner values mixed in
      for (int n = 0; n < RANDOM_TICKS; n++) begin
         if (n % 64 == 0) idle_odds = $urandom_range(0, 1) ? 3 : 0;
         if (n == PRESSURE_AT) hold_request = 1'b1;
         if (n == RANDOM_TICKS - QUIET_TICKS) quiet_tail = 1'b1;
         kind = $urandom_range(0, 9);
         if (kind < 6) begin
            // plausible: moderate speed and turn, short interval, sometimes zero
            speed    = 16'($urandom_range(0, 16383));
            speed    = speed - 16'sd8192;
            turn     = 16'($urandom_range(0, 32767));
            turn     = turn - 16'sd16384;
            interval = ($urandom_range(0, 15) == 0) ? 16'd0
                                                     : 16'($urandom_range(1, 4000));
         end else if (kind < 9) begin
            // anything the fields allow
            speed    = 16'($urandom);
            turn     = 16'($urandom);
            interval = 16'($urandom);
         end else begin
            speed    = corner16();
            turn     = corner16();
            interval = corner16();
         end
         offer_tick(speed, turn, interval, 1'b0, '0);
      end
      req_valid <= 1'b0;

      // wait for every owed pose, then a little longer for strays
      while (pending_poses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("PASS unicycle_pose_integrator");
      else
         $display("FAIL unicycle_pose_integrator");
      $finish;
   end

endmodule
